>>> sv/fsfp_pkg.sv
// Shared types, codes and helpers for the format spec field parser.
package fsfp_pkg;

    // Saturation limit for decimal width and precision
    localparam logic [30:0] SatMax = 31'h7FFF_FFFF;

    // Raw input transfer
    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_arg;
        logic               last;
    } item_t;

    // Result transfer
    typedef struct packed {
        logic               left_justify;
        logic               force_sign;
        logic               space_sign;
        logic               alt_form;
        logic               zero_pad;
        logic [30:0]        min_width;
        logic signed [31:0] precision;
        logic [7:0]         conversion;
    } result_t;

    // Character classes decided by the front end
    typedef enum logic [3:0] {
        CLS_MINUS = 4'd0,
        CLS_PLUS  = 4'd1,
        CLS_SPACE = 4'd2,
        CLS_HASH  = 4'd3,
        CLS_ZERO  = 4'd4,
        CLS_DIGIT = 4'd5,
        CLS_STAR  = 4'd6,
        CLS_DOT   = 4'd7,
        CLS_OTHER = 4'd8
    } cls_t;

    // Classified character as it travels from front to back
    typedef struct packed {
        cls_t               cls;
        logic [3:0]         digit;
        logic               int_conv;
        logic               last;
        logic signed [31:0] star_arg;
        logic [7:0]         ch;
    } cls_item_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Back end activity
    typedef struct packed {
        logic take;
        logic take_last;
    } back_status_t;

    // Width scan phase
    typedef enum logic [3:0] {
        WP_FLAGS  = 4'b0001,
        WP_SEEK   = 4'b0010,
        WP_DIGITS = 4'b0100,
        WP_DONE   = 4'b1000
    } wphase_t;

    // Precision scan phase
    typedef enum logic [3:0] {
        DP_NONE   = 4'b0001,
        DP_JUST   = 4'b0010,
        DP_DIGITS = 4'b0100,
        DP_DONE   = 4'b1000
    } dphase_t;

    // Flag bit positions
    localparam int FbMinus = 0;
    localparam int FbPlus  = 1;
    localparam int FbSpace = 2;
    localparam int FbHash  = 3;
    localparam int FbZero  = 4;

    // v * 10 + d, saturated
    function automatic logic [30:0] dec_push(input logic [30:0] v, input logic [3:0] d);
        logic [34:0] r;
        r = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {31'd0, d};
        if (r > {4'd0, SatMax})
            return SatMax;
        else
            return r[30:0];
    endfunction

endpackage

>>> sv/fsfp_front.sv
// Front end: classifies each incoming character.
module fsfp_front (
    input  fsfp_pkg::item_t     item,
    output fsfp_pkg::cls_item_t cls_item
);

    logic [7:0] c;
    logic       is_dig;

    assign c      = item.ch;
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);

    // Character class, payload and integer conversion test ("diuxX")
    always_comb
    begin
        cls_item.cls = fsfp_pkg::CLS_OTHER;
        priority if (c == 8'h2D)
            cls_item.cls = fsfp_pkg::CLS_MINUS;
        else if (c == 8'h2B)
            cls_item.cls = fsfp_pkg::CLS_PLUS;
        else if (c == 8'h20)
            cls_item.cls = fsfp_pkg::CLS_SPACE;
        else if (c == 8'h23)
            cls_item.cls = fsfp_pkg::CLS_HASH;
        else if (c == 8'h30)
            cls_item.cls = fsfp_pkg::CLS_ZERO;
        else if (is_dig)
            cls_item.cls = fsfp_pkg::CLS_DIGIT;
        else if (c == 8'h2A)
            cls_item.cls = fsfp_pkg::CLS_STAR;
        else if (c == 8'h2E)
            cls_item.cls = fsfp_pkg::CLS_DOT;
        else
            cls_item.cls = fsfp_pkg::CLS_OTHER;
        cls_item.digit    = c[3:0];
        cls_item.int_conv = (c == 8'h64) || (c == 8'h69) || (c == 8'h75) ||
                            (c == 8'h78) || (c == 8'h58);
        cls_item.last     = item.last;
        cls_item.star_arg = item.star_arg;
        cls_item.ch       = c;
    end

endmodule

>>> sv/fsfp_queue.sv
// Two-entry queue of classified characters between front and back.
module fsfp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  fsfp_pkg::cls_item_t wr_data,
    input  logic                rd,
    output fsfp_pkg::cls_item_t rd_data,
    output fsfp_pkg::q_status_t status
);

    fsfp_pkg::cls_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign do_wr        = wr && !status.full;
    assign do_rd        = rd && !status.empty;
    assign rd_data      = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> sv/fsfp_back.sv
// Back end: runs the field scan and holds the finished result.
module fsfp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fsfp_pkg::cls_item_t    cls_item,
    input  logic                   q_empty,
    output logic                   q_rd,
    input  logic                   pop,
    output logic                   empty,
    output fsfp_pkg::result_t      result,
    output fsfp_pkg::back_status_t status
);

    fsfp_pkg::wphase_t  wp_reg, wp_next, wp_scan;
    fsfp_pkg::dphase_t  dp_reg, dp_next, dp_scan;
    logic [4:0]         fl_reg, fl_next, fl_scan;
    logic [30:0]        wv_reg, wv_next, wv_scan;
    logic [31:0]        pv_reg, pv_next, pv_scan;
    logic               out_valid_reg, out_valid_next;
    fsfp_pkg::result_t  out_reg, out_next, res;
    logic               is_dig, do_seek, do_dot, take;
    logic [31:0]        neg_mag;
    logic [4:0]         f;

    assign is_dig  = (cls_item.cls == fsfp_pkg::CLS_ZERO) ||
                     (cls_item.cls == fsfp_pkg::CLS_DIGIT);
    assign neg_mag = 32'd0 - cls_item.star_arg;

    // Consume when a result slot is free, or the item makes no result
    assign take   = !q_empty && (!cls_item.last || !out_valid_reg || pop);
    assign q_rd   = take;
    assign status.take      = take;
    assign status.take_last = take && cls_item.last;

    // Field scan for one character
    always_comb
    begin
        wp_scan = wp_reg;
        dp_scan = dp_reg;
        fl_scan = fl_reg;
        wv_scan = wv_reg;
        pv_scan = pv_reg;
        do_seek = 1'b0;
        do_dot  = 1'b0;
        unique case (dp_reg)
            fsfp_pkg::DP_NONE:
            begin
                unique case (wp_reg)
                    fsfp_pkg::WP_FLAGS:
                    begin
                        unique case (cls_item.cls)
                            fsfp_pkg::CLS_MINUS: fl_scan[fsfp_pkg::FbMinus] = 1'b1;
                            fsfp_pkg::CLS_PLUS:  fl_scan[fsfp_pkg::FbPlus]  = 1'b1;
                            fsfp_pkg::CLS_SPACE: fl_scan[fsfp_pkg::FbSpace] = 1'b1;
                            fsfp_pkg::CLS_HASH:  fl_scan[fsfp_pkg::FbHash]  = 1'b1;
                            fsfp_pkg::CLS_ZERO:
                            begin
                                // second zero starts the width digits
                                if (fl_reg[fsfp_pkg::FbZero])
                                begin
                                    wv_scan = 31'd0;
                                    wp_scan = fsfp_pkg::WP_DIGITS;
                                end
                                else
                                    fl_scan[fsfp_pkg::FbZero] = 1'b1;
                            end
                            default: do_seek = 1'b1;
                        endcase
                    end
                    fsfp_pkg::WP_SEEK:
                        do_seek = 1'b1;
                    fsfp_pkg::WP_DIGITS:
                    begin
                        if (is_dig)
                            wv_scan = fsfp_pkg::dec_push(wv_reg, cls_item.digit);
                        else
                        begin
                            wp_scan = fsfp_pkg::WP_DONE;
                            do_dot  = (cls_item.cls == fsfp_pkg::CLS_DOT);
                        end
                    end
                    fsfp_pkg::WP_DONE:
                        do_dot = (cls_item.cls == fsfp_pkg::CLS_DOT);
                    default:
                        wp_scan = wp_reg;
                endcase
                // Looking for the width
                if (do_seek)
                begin
                    priority if (is_dig)
                    begin
                        wv_scan = {27'd0, cls_item.digit};
                        wp_scan = fsfp_pkg::WP_DIGITS;
                    end
                    else if (cls_item.cls == fsfp_pkg::CLS_STAR)
                    begin
                        if (cls_item.star_arg[31])
                        begin
                            wv_scan = neg_mag[31] ? fsfp_pkg::SatMax : neg_mag[30:0];
                            fl_scan[fsfp_pkg::FbMinus] = 1'b1;
                        end
                        else
                            wv_scan = cls_item.star_arg[30:0];
                        wp_scan = fsfp_pkg::WP_DONE;
                    end
                    else if (cls_item.cls == fsfp_pkg::CLS_DOT)
                    begin
                        wp_scan = fsfp_pkg::WP_DONE;
                        do_dot  = 1'b1;
                    end
                    else
                        wp_scan = fsfp_pkg::WP_SEEK;
                end
                if (do_dot)
                begin
                    dp_scan = fsfp_pkg::DP_JUST;
                    pv_scan = 32'd0;
                end
            end
            fsfp_pkg::DP_JUST:
            begin
                if (is_dig)
                begin
                    pv_scan = {28'd0, cls_item.digit};
                    dp_scan = fsfp_pkg::DP_DIGITS;
                end
                else
                begin
                    if (cls_item.cls == fsfp_pkg::CLS_STAR)
                        pv_scan = cls_item.star_arg;
                    dp_scan = fsfp_pkg::DP_DONE;
                end
            end
            fsfp_pkg::DP_DIGITS:
            begin
                if (is_dig)
                    pv_scan = {1'b0, fsfp_pkg::dec_push(pv_reg[30:0], cls_item.digit)};
                else
                    dp_scan = fsfp_pkg::DP_DONE;
            end
            fsfp_pkg::DP_DONE:
                dp_scan = dp_reg;
            default:
                dp_scan = dp_reg;
        endcase
    end

    // Flag conflict rules and result fields
    always_comb
    begin
        f = fl_scan;
        if (f[fsfp_pkg::FbMinus])
            f[fsfp_pkg::FbZero] = 1'b0;
        if (cls_item.int_conv && !pv_scan[31])
            f[fsfp_pkg::FbZero] = 1'b0;
        if (f[fsfp_pkg::FbPlus])
            f[fsfp_pkg::FbSpace] = 1'b0;
        res.left_justify = f[fsfp_pkg::FbMinus];
        res.force_sign   = f[fsfp_pkg::FbPlus];
        res.space_sign   = f[fsfp_pkg::FbSpace];
        res.alt_form     = f[fsfp_pkg::FbHash];
        res.zero_pad     = f[fsfp_pkg::FbZero];
        res.min_width    = wv_scan;
        res.precision    = pv_scan;
        res.conversion   = cls_item.ch;
    end

    // State update; the conversion character returns the scan to reset
    always_comb
    begin
        wp_next        = wp_reg;
        dp_next        = dp_reg;
        fl_next        = fl_reg;
        wv_next        = wv_reg;
        pv_next        = pv_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && pop)
            out_valid_next = 1'b0;
        if (take)
        begin
            if (cls_item.last)
            begin
                wp_next        = fsfp_pkg::WP_FLAGS;
                dp_next        = fsfp_pkg::DP_NONE;
                fl_next        = 5'd0;
                wv_next        = 31'd0;
                pv_next        = 32'hFFFF_FFFF;
                out_valid_next = 1'b1;
                out_next       = res;
            end
            else
            begin
                wp_next = wp_scan;
                dp_next = dp_scan;
                fl_next = fl_scan;
                wv_next = wv_scan;
                pv_next = pv_scan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= fsfp_pkg::WP_FLAGS;
            dp_reg        <= fsfp_pkg::DP_NONE;
            fl_reg        <= 5'd0;
            wv_reg        <= 31'd0;
            pv_reg        <= 32'hFFFF_FFFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            dp_reg        <= dp_next;
            fl_reg        <= fl_next;
            wv_reg        <= wv_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

>>> sv/format_spec_field_parser.sv
// Top level of the printf-style format spec field parser.
// Takes one conversion-token character per transfer (after the '%', the conversion
// letter marked by last) and gives one result of flags, minimum width, precision and
// conversion letter per token. A character is taken every cycle while full is low:
// the front end classifies it into a two-entry queue, and the back end scans one
// character per cycle unless a conversion character waits on a held result. A result
// reaches the result ports from the output register after its last character passes
// through the queue and the back end. A finished result waits in the output register
// while the next token's characters keep flowing; push stalls only when that register
// is still held and a conversion character is waiting behind it with the queue full.
module format_spec_field_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  fsfp_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output fsfp_pkg::result_t result
);

    fsfp_pkg::cls_item_t    cls_in, cls_out;
    fsfp_pkg::q_status_t    q_status;
    fsfp_pkg::back_status_t b_status;
    logic                   q_rd;

    assign full = q_status.full;

    fsfp_front u_front (
        .item     (item),
        .cls_item (cls_in)
    );

    fsfp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_data (cls_in),
        .rd      (q_rd),
        .rd_data (cls_out),
        .status  (q_status)
    );

    fsfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cls_item (cls_out),
        .q_empty  (q_status.empty),
        .q_rd     (q_rd),
        .pop      (pop),
        .empty    (empty),
        .result   (result),
        .status   (b_status)
    );

    // A result appears only from a consumed conversion character
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(b_status.take_last))
        else $error("result appeared without a conversion character");

    // A full queue is never empty in the next cycle
    a_full_drain: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |=> !q_status.empty)
        else $error("queue drained too fast");

    // The back end only consumes what is queued
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        b_status.take |-> !q_status.empty)
        else $error("back end took from an empty queue");

    // A held result blocks a further conversion unless it is popped
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (b_status.take_last && !empty) |-> pop)
        else $error("result overwritten");

endmodule
